@@ rtl/core/rgbc_pkg.sv @@
// rgbc_pkg: shared types, register indexes and the emboss kernel function
// for the 3x3 emboss filter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

   localparam int NUM_LANES = 6;
   localparam int DIV_STEPS = 8;

   typedef logic [23:0] pix_type;

   // one window column: top row first
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] nq;
   } lane_type;

   // one entry of the divide chain: sideband plus six quotient lanes
   typedef struct packed {
      logic                      vld;
      logic                      has_a;
      logic                      has_b;
      logic                      last;
      lane_type [NUM_LANES-1:0]  lane;
   } stage_type;

   typedef struct packed {
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
      logic       last;
   } result_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   typedef logic [1:0] csr_addr_type;

   localparam csr_addr_type REG_WIDTH   = 2'd0;
   localparam csr_addr_type REG_HEIGHT  = 2'd1;
   localparam csr_addr_type REG_DIVISOR = 2'd2;

   // kernel {-2,-1,0},{-1,1,1},{0,1,2}, clamped to 0..255, per channel
   function automatic pix_type emboss(input col_type l, input col_type m, input col_type r);
      pix_type            res;
      logic signed [11:0] tl, tc, ml, mc, mr, bc, br, s;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         tl = $signed({4'b0000, l.top[8*ch +: 8]});
         tc = $signed({4'b0000, m.top[8*ch +: 8]});
         ml = $signed({4'b0000, l.mid[8*ch +: 8]});
         mc = $signed({4'b0000, m.mid[8*ch +: 8]});
         mr = $signed({4'b0000, r.mid[8*ch +: 8]});
         bc = $signed({4'b0000, m.bot[8*ch +: 8]});
         br = $signed({4'b0000, r.bot[8*ch +: 8]});
         s  = (br <<< 1) + bc + mr + mc - (tl <<< 1) - tc - ml;
         if (s < 12'sd0) begin
            res[8*ch +: 8] = 8'h00;
         end else if (s > 12'sd255) begin
            res[8*ch +: 8] = 8'hFF;
         end else begin
            res[8*ch +: 8] = s[7:0];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/rgbc_col_cell.sv @@
// rgbc_col_cell: one column of the 3-row window, shifted along the row
// depends on rgbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbc_col_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             clr,
   input  logic             en,
   input  rgbc_pkg::col_type din,
   output rgbc_pkg::col_type q
);
   import rgbc_pkg::*;

   col_type col_ff;
   col_type col_in;

   always_comb begin
      col_in = col_ff;
      if (clr) begin
         col_in = '0;
      end else if (en) begin
         col_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign q = col_ff;

endmodule

`default_nettype wire

@@ rtl/core/rgbc_div_cell.sv @@
// rgbc_div_cell: one restoring-division step (one quotient bit) for six lanes
// depends on rgbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbc_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [7:0]         divisor,
   input  rgbc_pkg::stage_type din,
   output rgbc_pkg::stage_type dout
);
   import rgbc_pkg::*;

   logic      vld_ff;
   stage_type data_ff;
   stage_type data_in;
   logic [8:0] part;

   always_comb begin
      data_in = din;
      part    = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         part = {din.lane[i].rem, din.lane[i].nq[7]};
         if (part >= {1'b0, divisor}) begin
            data_in.lane[i].rem = 8'(part - {1'b0, divisor});
            data_in.lane[i].nq  = {din.lane[i].nq[6:0], 1'b1};
         end else begin
            data_in.lane[i].rem = part[7:0];
            data_in.lane[i].nq  = {din.lane[i].nq[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= din.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      dout     = data_ff;
      dout.vld = vld_ff;
   end

endmodule

`default_nettype wire

@@ rtl/core/rgb_conv3x3_emboss_unit.sv @@
// rgb_conv3x3_emboss_unit: streaming 3x3 emboss filter, top level
// depends on rgbc_pkg, rgbc_col_cell, rgbc_div_cell
//
//  channel | ports                         | beat
//  --------+-------------------------------+-----------------------------------
//  req     | req_valid/req_ready           | one pixel (three channels) or pad
//  rsp     | rsp_valid/rsp_ready           | one filtered centre, frame_last
//  csr     | csr_valid/csr_ready           | register index and write data
//
// an accepted pixel is read from the single line store port on the accept
// cycle and written back at launch, which a held divide chain can delay
// rsp_valid rises after the pixel's req beat has passed the pixel latch, the
// 8 divide cells, then the result buffer
// reset is synchronous; the line store needs no clearing pass, rows above the
// frame are masked
// a stalled rsp beat holds the divide chain, which then holds the req side

`timescale 1ns / 1ps
`default_nettype none

module rgb_conv3x3_emboss_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_channel0_in,
   input  logic [7:0]             req_channel1_in,
   input  logic [7:0]             req_channel2_in,
   input  logic                   req_pad,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_channel0_out,
   output logic [7:0]             rsp_channel1_out,
   output logic [7:0]             rsp_channel2_out,
   output logic                   rsp_frame_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  rgbc_pkg::csr_addr_type csr_addr,
   input  logic [15:0]            csr_wdata
);
   import rgbc_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RESET_W = (640 < MAX_WIDTH) ? 640 : MAX_WIDTH;
   localparam logic [AW-1:0] LAST_MAX   = AW'(MAX_WIDTH - 1);
   localparam logic [AW-1:0] LAST_RESET = AW'(RESET_W - 1);
   localparam logic [13:0]   MAX_W14    = 14'(MAX_WIDTH);

   // configuration, held in effective form
   logic [AW-1:0] width_last_ff, width_last_in;
   logic [15:0]   height_ff, height_in;
   logic [7:0]    divisor_ff, divisor_in;
   logic          csr_we, restart;
   logic [12:0]   w_raw, w_diff;

   state_type     state_ff, state_in;
   logic [AW-1:0] column_count_ff, column_count_in;
   logic [15:0]   row_count_ff, row_count_in;
   pix_type       pix_ff;
   logic [47:0]   rd_data_ff;
   logic [47:0]   line_mem [MAX_WIDTH];

   logic          accept, launch, div_en, col_first, col_last, row_any;
   pix_type       top_px, mid_px, res_a, res_b;
   col_type       new_col, cell0_q, cell1_q, cell1_d, win_a, win_b;
   stage_type     stage [DIV_STEPS+1];

   result_type    slot0_ff, slot0_in, slot1_ff, slot1_in, out_a, out_b;
   logic [1:0]    out_cnt_ff, out_cnt_in;
   logic          load, pop;

   // configuration port
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;
   assign restart   = csr_we && (csr_addr == REG_WIDTH || csr_addr == REG_HEIGHT);
   assign w_raw     = csr_wdata[12:0];
   assign w_diff    = w_raw - 13'd1;

   always_comb begin
      width_last_in = width_last_ff;
      height_in     = height_ff;
      divisor_in    = divisor_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_WIDTH: begin
               if (w_raw == 13'd0) begin
                  width_last_in = '0;
               end else if ({1'b0, w_raw} > MAX_W14) begin
                  width_last_in = LAST_MAX;
               end else begin
                  width_last_in = w_diff[AW-1:0];
               end
            end
            REG_HEIGHT: begin
               height_in = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
            end
            REG_DIVISOR: begin
               divisor_in = (csr_wdata[7:0] == 8'd0) ? 8'd1 : csr_wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= LAST_RESET;
         height_ff     <= 16'd480;
         divisor_ff    <= 8'd1;
      end else begin
         width_last_ff <= width_last_in;
         height_ff     <= height_in;
         divisor_ff    <= divisor_in;
      end
   end

   // sequencer: accept and read, then compute and write back
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_CALC;
         ST_CALC: if (div_en) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      launch    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CALC: launch = div_en;
      endcase
   end

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // pixel latch; pads and drain-row pixels read as zero
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_pad || row_count_ff >= height_ff) begin
            pix_ff <= '0;
         end else begin
            pix_ff <= {req_channel2_in, req_channel1_in, req_channel0_in};
         end
      end
   end

   // line store: previous row low, row before it high
   always_ff @(posedge clock) begin
      if (launch) begin
         line_mem[column_count_ff] <= {mid_px, pix_ff};
      end
      if (accept) begin
         rd_data_ff <= line_mem[column_count_ff];
      end
   end

   assign row_any   = (row_count_ff != 16'd0);
   assign col_first = (column_count_ff == '0);
   assign col_last  = (column_count_ff == width_last_ff);
   assign mid_px    = row_any ? rd_data_ff[23:0] : '0;
   assign top_px    = (|row_count_ff[15:1]) ? rd_data_ff[47:24] : '0;

   assign new_col = '{top: top_px, mid: mid_px, bot: pix_ff};
   assign cell1_d = col_first ? '0 : cell0_q;

   rgbc_col_cell u_col0 (
      .clock (clock),
      .reset (reset),
      .clr   (restart),
      .en    (launch),
      .din   (new_col),
      .q     (cell0_q)
   );

   rgbc_col_cell u_col1 (
      .clock (clock),
      .reset (reset),
      .clr   (restart),
      .en    (launch),
      .din   (cell1_d),
      .q     (cell1_q)
   );

   // the window restarts at the left edge of every row
   assign win_a = col_first ? '0 : cell0_q;
   assign win_b = col_first ? '0 : cell1_q;
   assign res_a = emboss(win_b, win_a, new_col);
   assign res_b = emboss(win_a, new_col, '0);

   always_comb begin
      stage[0]       = '0;
      stage[0].vld   = launch;
      stage[0].has_a = row_any && !col_first;
      stage[0].has_b = row_any && col_last;
      stage[0].last  = (row_count_ff == height_ff);
      for (int i = 0; i < 3; i++) begin
         stage[0].lane[i].nq   = res_a[8*i +: 8];
         stage[0].lane[i+3].nq = res_b[8*i +: 8];
      end
   end

   // position counters
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (restart) begin
         column_count_in = '0;
         row_count_in    = '0;
      end else if (launch) begin
         if (col_last) begin
            column_count_in = '0;
            row_count_in    = (row_count_ff == height_ff) ? 16'd0 : row_count_ff + 16'd1;
         end else begin
            column_count_in = column_count_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // divide chain, one quotient bit per cell
   assign div_en = !(stage[DIV_STEPS].vld && out_cnt_ff != 2'd0);

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      rgbc_div_cell u_div (
         .clock   (clock),
         .reset   (reset),
         .en      (div_en),
         .divisor (divisor_ff),
         .din     (stage[g]),
         .dout    (stage[g+1])
      );
   end

   // result buffer, two beats deep
   always_comb begin
      out_a = '{ch0: stage[DIV_STEPS].lane[0].nq, ch1: stage[DIV_STEPS].lane[1].nq,
                ch2: stage[DIV_STEPS].lane[2].nq, last: 1'b0};
      out_b = '{ch0: stage[DIV_STEPS].lane[3].nq, ch1: stage[DIV_STEPS].lane[4].nq,
                ch2: stage[DIV_STEPS].lane[5].nq, last: stage[DIV_STEPS].last};
   end

   assign load = stage[DIV_STEPS].vld && (out_cnt_ff == 2'd0);
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      out_cnt_in = out_cnt_ff;
      priority if (load) begin
         if (stage[DIV_STEPS].has_a) begin
            slot0_in   = out_a;
            slot1_in   = out_b;
            out_cnt_in = stage[DIV_STEPS].has_b ? 2'd2 : 2'd1;
         end else if (stage[DIV_STEPS].has_b) begin
            slot0_in   = out_b;
            out_cnt_in = 2'd1;
         end
      end else if (pop) begin
         slot0_in   = slot1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid        = (out_cnt_ff != 2'd0);
   assign rsp_channel0_out = slot0_ff.ch0;
   assign rsp_channel1_out = slot0_ff.ch1;
   assign rsp_channel2_out = slot0_ff.ch2;
   assign rsp_frame_last   = slot0_ff.last;

endmodule

`default_nettype wire

@@ rtl/core/rgbc_checker.sv @@
// rgbc_checker: port-level checks on rgb_conv3x3_emboss_unit, and its bind
// depends on rgb_conv3x3_emboss_unit
`timescale 1ns / 1ps
`default_nettype none

module rgbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_channel0_out,
   input logic [7:0] rsp_channel1_out,
   input logic [7:0] rsp_channel2_out,
   input logic       rsp_frame_last
);

   // a stalled rsp beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a stalled rsp beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_channel0_out) && $stable(rsp_channel1_out)
         && $stable(rsp_channel2_out) && $stable(rsp_frame_last))
      else $error("rsp payload changed while stalled");

   // reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat present right after reset");

   // an accepted pixel drops req_ready, as its line store entry must be written back
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken on back-to-back cycles");

endmodule

bind rgb_conv3x3_emboss_unit rgbc_checker u_rgbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_channel0_out (rsp_channel0_out),
   .rsp_channel1_out (rsp_channel1_out),
   .rsp_channel2_out (rsp_channel2_out),
   .rsp_frame_last   (rsp_frame_last)
);

`default_nettype wire

@@ sim/tb.sv @@
// tb: self-checking testbench for rgb_conv3x3_emboss_unit, a streaming 3x3 emboss filter
// predicts every filtered centre from its own line store and window copy
// depends on rgbc_pkg and the rgb_conv3x3_emboss_unit rtl
`timescale 1ns / 1ps

module tb;
   import rgbc_pkg::*;

   localparam int MAX_WIDTH = 4096;
   localparam int RANDOM_ITEMS = 560;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS = 10_000_000;
   // no register behind this index, writes to it are dropped
   localparam csr_addr_type REG_SPARE = 2'd3;

   typedef struct packed {
      logic       pad;
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
   } pixel_in_type;

   // window columns indexed [x][y]: x 0 left .. 2 right, y 0 top .. 2 bottom
   typedef logic [2:0][2:0][23:0] window_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [7:0]   req_channel0_in = '0;
   logic [7:0]   req_channel1_in = '0;
   logic [7:0]   req_channel2_in = '0;
   logic         req_pad = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [7:0]   rsp_channel0_out;
   logic [7:0]   rsp_channel1_out;
   logic [7:0]   rsp_channel2_out;
   logic         rsp_frame_last;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_addr_type csr_addr = REG_WIDTH;
   logic [15:0]  csr_wdata = '0;

   // predictor state
   logic [12:0]  width_reg = 13'd640;
   logic [15:0]  height_reg = 16'd480;
   logic [7:0]   divisor_reg = 8'd1;
   logic [47:0]  line_mem [0:MAX_WIDTH-1];
   logic [23:0]  column_history [0:5];
   int           next_col = 0;
   int           next_row = 0;

   result_type   pending_centres [$];
   int           fail_count = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;

   rgb_conv3x3_emboss_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel0_in  (req_channel0_in),
      .req_channel1_in  (req_channel1_in),
      .req_channel2_in  (req_channel2_in),
      .req_pad          (req_pad),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel0_out (rsp_channel0_out),
      .rsp_channel1_out (rsp_channel1_out),
      .rsp_channel2_out (rsp_channel2_out),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
   end

   // kernel {-2,-1,0},{-1,1,1},{0,1,2}, clamp to 0..255, then truncating divide
   function automatic result_type embossed_centre(input window_type win, input logic last);
      result_type      res;
      int              d, s, tl, tc, ml, mc, mr, bc, br;
      logic [2:0][7:0] q;
      d = (divisor_reg == 0) ? 1 : int'(divisor_reg);
      for (int ch = 0; ch < 3; ch++) begin
         tl = int'(win[0][0][8*ch +: 8]);
         tc = int'(win[1][0][8*ch +: 8]);
         ml = int'(win[0][1][8*ch +: 8]);
         mc = int'(win[1][1][8*ch +: 8]);
         mr = int'(win[2][1][8*ch +: 8]);
         bc = int'(win[1][2][8*ch +: 8]);
         br = int'(win[2][2][8*ch +: 8]);
         s = 2 * br + bc + mr + mc - 2 * tl - tc - ml;
         if (s < 0) begin
            s = 0;
         end else if (s > 255) begin
            s = 255;
         end
         q[ch] = 8'(s / d);
      end
      res.ch0 = q[0];
      res.ch1 = q[1];
      res.ch2 = q[2];
      res.last = last;
      return res;
   endfunction

   task automatic restart_frame();
      for (int i = 0; i < 6; i++) column_history[i] = '0;
      next_col = 0;
      next_row = 0;
   endtask

   // advance the filter by one accepted beat and queue the centres it completes
   task automatic emboss_pixel(input pixel_in_type px);
      int          w, h, col, row;
      logic [23:0] pix, top, mid;
      logic [47:0] entry;
      window_type  win;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg == 0) ? 1 : int'(height_reg);
      col = next_col;
      row = next_row;
      // pads and anything in the drain row read as a black pixel
      pix = (px.pad || row >= h) ? 24'h0 : {px.ch2, px.ch1, px.ch0};
      entry = line_mem[col];
      mid = (row >= 1) ? entry[23:0] : 24'h0;
      top = (row >= 2) ? entry[47:24] : 24'h0;
      line_mem[col] = {mid, pix};
      if (col == 0) begin
         for (int i = 0; i < 6; i++) column_history[i] = '0;
      end
      if (row >= 1) begin
         if (col >= 1) begin
            for (int y = 0; y < 3; y++) begin
               win[0][y] = column_history[3 + y];
               win[1][y] = column_history[y];
            end
            win[2] = {pix, mid, top};
            pending_centres.push_back(embossed_centre(win, 1'b0));
         end
         // right edge: centre is the column just arrived, right neighbours zero
         if (col == w - 1) begin
            for (int y = 0; y < 3; y++) begin
               win[0][y] = (col >= 1) ? column_history[y] : 24'h0;
            end
            win[1] = {pix, mid, top};
            win[2] = '0;
            pending_centres.push_back(embossed_centre(win, row == h));
         end
      end
      for (int y = 0; y < 3; y++) column_history[3 + y] = column_history[y];
      column_history[0] = top;
      column_history[1] = mid;
      column_history[2] = pix;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row > h) begin
            row = 0;
            for (int i = 0; i < 6; i++) column_history[i] = '0;
         end
      end
      next_col = col;
      next_row = row;
   endtask

   task automatic send_pixel(input pixel_in_type px);
      int gap;
      gap = 0;
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_pad <= px.pad;
      req_channel0_in <= px.ch0;
      req_channel1_in <= px.ch1;
      req_channel2_in <= px.ch2;
      do @(posedge clock); while (!req_ready);
      emboss_pixel(px);
   endtask

   task automatic csr_write(input csr_addr_type addr, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (addr)
         REG_WIDTH: begin
            width_reg = data[12:0];
            restart_frame();
         end
         REG_HEIGHT: begin
            height_reg = data;
            restart_frame();
         end
         REG_DIVISOR: begin
            divisor_reg = data[7:0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending, let every expected centre come out, then allow for beats
   // still in flight that produce nothing
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_centres.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_in_type random_pixel(input logic pad);
      pixel_in_type px;
      px.pad = pad;
      px.ch0 = rand_channel();
      px.ch1 = rand_channel();
      px.ch2 = rand_channel();
      return px;
   endfunction

   function automatic pixel_in_type make_pixel(input logic pad, input logic [7:0] c0,
                                               input logic [7:0] c1, input logic [7:0] c2);
      pixel_in_type px;
      px.pad = pad;
      px.ch0 = c0;
      px.ch1 = c1;
      px.ch2 = c2;
      return px;
   endfunction

   // reset sizes 640 x 480 and divisor 1: fill row 0, get into row 1
   task automatic test_reset_values();
      for (int i = 0; i < 645; i++) send_pixel(random_pixel(1'b0));
      settle();
   endtask

   task automatic test_directed();
      settle();
      csr_write(REG_WIDTH, 16'd3);
      csr_write(REG_HEIGHT, 16'd2);
      csr_write(REG_DIVISOR, 16'd1);
      // dark row over bright row, a pad inside the frame, pixels in the drain row
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(1'b0, 8'hFF, 8'h80, 8'h01));
      send_pixel(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(1'b0, 8'hAA, 8'h55, 8'hFF));
      send_pixel(make_pixel(1'b1, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(1'b0, 8'h12, 8'h34, 8'h56));
      // bright over dark drives the sums negative; frame wraps straight in
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF));
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));
      for (int i = 0; i < 3; i++) send_pixel(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
      settle();
      // zero sizes and divisor act as one
      csr_write(REG_WIDTH, 16'd0);
      csr_write(REG_HEIGHT, 16'd0);
      csr_write(REG_DIVISOR, 16'd0);
      for (int i = 0; i < 2; i++) begin
         send_pixel(make_pixel(1'b0, 8'hFF, 8'h7F, 8'h01));
         send_pixel(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
      end
      settle();
   endtask

   task automatic test_register_limits();
      // width above the line store clamps to 4096 columns; a short run in its first row
      csr_write(REG_WIDTH, 16'hFFFF);
      csr_write(REG_HEIGHT, 16'd1);
      csr_write(REG_DIVISOR, 16'd3);
      for (int i = 0; i < 16; i++) send_pixel(random_pixel(1'b0));
      settle();
      // upper width bits are dropped, tallest frame, largest divisor
      csr_write(REG_WIDTH, 16'hE002);
      csr_write(REG_HEIGHT, 16'hFFFF);
      csr_write(REG_DIVISOR, 16'hFF);
      for (int i = 0; i < 12; i++) send_pixel(random_pixel(1'b0));
      settle();
      // must neither change a register nor restart the frame
      csr_write(REG_SPARE, 16'($urandom_range(16'hFFFF)));
      for (int i = 0; i < 8; i++) send_pixel(random_pixel(1'b0));
      settle();
   endtask

   task automatic test_random(input int send_pct, input int stall_pct);
      int sent, w, h, frames, total, stop_at, row;
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
         settle();
         w = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(8, 1);
         h = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(4, 1);
         csr_write(REG_WIDTH, 16'(w) | (16'($urandom_range(7)) << 13));
         csr_write(REG_HEIGHT, 16'(h));
         if ($urandom_range(1) == 1) begin
            csr_write(REG_DIVISOR,
                      ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'd1);
         end
         frames = $urandom_range(2, 1);
         total = (h + 1) * w * frames;
         // now and then a frame is cut short by the next reconfiguration
         stop_at = ($urandom_range(7) == 0) ? $urandom_range(total - 1, 1) : total;
         for (int pos = 0; pos < stop_at; pos++) begin
            row = (pos / w) % (h + 1);
            if (row < h) begin
               send_pixel(random_pixel($urandom_range(15) == 0));
            end else begin
               send_pixel(random_pixel($urandom_range(3) != 0));
            end
            sent++;
         end
      end
      settle();
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_centres.size() == 0) begin
            $error("unexpected result beat: %0d %0d %0d last %0d", rsp_channel0_out,
                   rsp_channel1_out, rsp_channel2_out, rsp_frame_last);
            fail_count++;
         end else begin
            want = pending_centres.pop_front();
            if (rsp_channel0_out !== want.ch0) begin
               $error("channel0_out: expected %0d, got %0d", want.ch0, rsp_channel0_out);
               fail_count++;
            end
            if (rsp_channel1_out !== want.ch1) begin
               $error("channel1_out: expected %0d, got %0d", want.ch1, rsp_channel1_out);
               fail_count++;
            end
            if (rsp_channel2_out !== want.ch2) begin
               $error("channel2_out: expected %0d, got %0d", want.ch2, rsp_channel2_out);
               fail_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0d, got %0d", want.last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      restart_frame();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed();
      test_register_limits();
      test_random(0, 0);
      test_random(61, 0);
      test_random(0, 61);
      test_random(31, 31);
      if (fail_count == 0 && pending_centres.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_col_cell.sv
rtl/core/rgbc_div_cell.sv
rtl/core/rgb_conv3x3_emboss_unit.sv
rtl/core/rgbc_checker.sv
sim/tb.sv
